// ----- design/nnt_pkg.sv -----
package nnt_pkg;

    // Fixed field widths of the channels
    localparam int PT_W         = 6;
    localparam int CNT_W        = 7;
    localparam int IN_COST_W    = 32;
    localparam int VIS_W        = 64;

    // Defaults for the top-level parameters
    localparam int MAX_POINTS_DEF = 64;
    localparam int COST_WIDTH_DEF = 32;

    // Configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;
    localparam logic [0:0] REG_POINTS_IN_USE = 1'b0;
    localparam logic [CNT_W-1:0] POINTS_RESET = 7'd64;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_SOLVE = 1'b1;

    typedef struct packed {
        logic            start;   // reset the running minimum
        logic            issue;   // read one entry this cycle
        logic            last;    // this read is the last column of the row
        logic [PT_W-1:0] row;
        logic [PT_W-1:0] col;
    } t_scan_ctl;

    typedef struct packed {
        logic            done;
        logic            hit;
        logic [PT_W-1:0] pick;
    } t_scan_res;

endpackage

// ----- design/nnt_in_if.sv -----
interface nnt_in_if;
    logic                          valid;
    logic                          ready;
    logic                          mode;
    logic [nnt_pkg::PT_W-1:0]      row;
    logic [nnt_pkg::PT_W-1:0]      col;
    logic [nnt_pkg::IN_COST_W-1:0] cost;
    logic [nnt_pkg::PT_W-1:0]      start_point;

    modport source (output valid, mode, row, col, cost, start_point, input ready);
    modport sink   (input valid, mode, row, col, cost, start_point, output ready);
endinterface

// ----- design/nnt_out_if.sv -----
interface nnt_out_if;
    logic                     valid;
    logic                     ready;
    logic [nnt_pkg::PT_W-1:0] tour_position;
    logic [nnt_pkg::PT_W-1:0] point_index;
    logic                     found;
    logic                     last;

    modport source (output valid, tour_position, point_index, found, last, input ready);
    modport sink   (input valid, tour_position, point_index, found, last, output ready);
endinterface

// ----- design/nnt_cost_scan.sv -----
module nnt_cost_scan #(
    parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
    parameter int COST_WIDTH = nnt_pkg::COST_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_wr_en,
    input  logic [nnt_pkg::PT_W-1:0]      i_wr_row,
    input  logic [nnt_pkg::PT_W-1:0]      i_wr_col,
    input  logic [nnt_pkg::IN_COST_W-1:0] i_wr_cost,
    input  nnt_pkg::t_scan_ctl            i_ctl,
    input  logic [nnt_pkg::VIS_W-1:0]     i_visited,
    output nnt_pkg::t_scan_res            o_res
);
    import nnt_pkg::*;

    localparam int DEPTH = MAX_POINTS * MAX_POINTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int LIM_W = $clog2(MAX_POINTS + 1) + PT_W;

    logic [COST_WIDTH-1:0] mem [DEPTH];

    logic                  wr_ok;
    logic [AW-1:0]         wr_addr;
    logic [AW-1:0]         rd_addr;
    logic [COST_WIDTH-1:0] r_rdata;
    logic                  r_rd_v;
    logic                  r_rd_last;
    logic [PT_W-1:0]       r_rd_col;
    logic [COST_WIDTH-1:0] r_best;
    logic [PT_W-1:0]       r_pick;
    logic                  r_hit;
    logic                  take;
    logic [COST_WIDTH-1:0] n_best;
    logic [PT_W-1:0]       n_pick;
    logic                  n_hit;

    // Drop loads that fall outside the stored matrix
    assign wr_ok   = i_wr_en
                   && (LIM_W'(i_wr_row) < LIM_W'(MAX_POINTS))
                   && (LIM_W'(i_wr_col) < LIM_W'(MAX_POINTS));
    assign wr_addr = AW'(32'(i_wr_row) * 32'(MAX_POINTS) + 32'(i_wr_col));
    assign rd_addr = AW'(32'(i_ctl.row) * 32'(MAX_POINTS) + 32'(i_ctl.col));

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            mem[wr_addr] <= COST_WIDTH'(i_wr_cost);
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_v <= 1'b0;
        end else begin
            r_rd_v <= i_ctl.issue;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_col  <= i_ctl.col;
        r_rd_last <= i_ctl.last;
    end

    // Keep only strictly smaller costs, so the lowest index wins ties
    assign take   = r_rd_v && !i_visited[r_rd_col] && (r_rdata < r_best);
    assign n_best = take ? r_rdata : r_best;
    assign n_pick = take ? r_rd_col : r_pick;
    assign n_hit  = take || r_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.start) begin
            r_hit <= 1'b0;
        end else begin
            r_hit <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_best <= '1;
        end else begin
            r_best <= n_best;
        end
        r_pick <= n_pick;
    end

    assign o_res.done = r_rd_v && r_rd_last;
    assign o_res.hit  = n_hit;
    assign o_res.pick = n_pick;

endmodule

// ----- design/nearest_neighbor_tour.sv -----
// Channel   Dir  Beat payload
// i_in      in   mode, row, col, cost, start_point
// o_out     out  tour_position, point_index, found, last
// apb       in   points_in_use at byte address 0
//
// A load beat writes the cost memory as it is accepted.
// A solve beat's start point is registered as the prepared beat and then moved to the output
// register; each later point takes N reads through the cost memory's single read port,
// the registered read data and a hand-over of the point to the output register.
// The input is taken only between tours.
// Reset is synchronous and active low; the cost memory is not cleared.
// A stalled output holds its beat in the output register while the tour waits.
module nearest_neighbor_tour #(
    parameter int MAX_POINTS = nnt_pkg::MAX_POINTS_DEF,
    parameter int COST_WIDTH = nnt_pkg::COST_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    nnt_in_if.sink                     i_in,
    nnt_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [nnt_pkg::APB_AW-1:0] paddr,
    input  logic [nnt_pkg::APB_DW-1:0] pwdata,
    output logic [nnt_pkg::APB_DW-1:0] prdata,
    output logic                       pready
);
    import nnt_pkg::*;

    localparam int CAP = (MAX_POINTS < VIS_W) ? MAX_POINTS : VIS_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EMIT = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;

    logic [1:0]       r_state, n_state;
    logic [CNT_W-1:0] r_pin;
    logic [CNT_W-1:0] r_n, n_n;
    logic [CNT_W-1:0] r_pos, n_pos;
    logic [CNT_W-1:0] r_col, n_col;
    logic [PT_W-1:0]  r_cur, n_cur;
    logic [VIS_W-1:0] r_vis, n_vis;
    logic [PT_W-1:0]  r_ptp, n_ptp;
    logic [PT_W-1:0]  r_ppt, n_ppt;
    logic             r_pfd, n_pfd;
    logic             r_plast, n_plast;
    logic             r_ovalid, n_ovalid;
    logic [PT_W-1:0]  r_otp, r_opt;
    logic             r_ofd, r_olast;
    logic             load_out;
    logic             acc;
    logic [CNT_W-1:0] act_n;
    t_scan_ctl        ctl;
    t_scan_res        res;

    // Configuration register
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POINTS_IN_USE) ? APB_DW'(r_pin) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pin <= POINTS_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_POINTS_IN_USE) begin
            r_pin <= pwdata[CNT_W-1:0];
        end
    end

    // Zero counts as one point; clamp to MAX_POINTS and to what the marks can hold
    assign act_n = (r_pin == '0) ? CNT_W'(1)
                 : (r_pin > CNT_W'(CAP)) ? CNT_W'(CAP) : r_pin;

    assign i_in.ready = (r_state == ST_IDLE);
    assign acc        = i_in.valid && i_in.ready;

    nnt_cost_scan #(
        .MAX_POINTS (MAX_POINTS),
        .COST_WIDTH (COST_WIDTH)
    ) u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (acc && i_in.mode == MODE_LOAD),
        .i_wr_row  (i_in.row),
        .i_wr_col  (i_in.col),
        .i_wr_cost (i_in.cost),
        .i_ctl     (ctl),
        .i_visited (r_vis),
        .o_res     (res)
    );

    always_comb begin
        n_state  = r_state;
        n_n      = r_n;
        n_pos    = r_pos;
        n_col    = r_col;
        n_cur    = r_cur;
        n_vis    = r_vis;
        n_ptp    = r_ptp;
        n_ppt    = r_ppt;
        n_pfd    = r_pfd;
        n_plast  = r_plast;
        load_out = 1'b0;
        ctl      = '0;
        ctl.row  = r_cur;
        ctl.col  = r_col[PT_W-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (acc && i_in.mode == MODE_SOLVE) begin
                    n_n     = act_n;
                    n_pos   = '0;
                    n_vis   = '0;
                    n_cur   = i_in.start_point;
                    n_ptp   = '0;
                    n_state = ST_EMIT;
                    if (CNT_W'(i_in.start_point) >= act_n) begin
                        n_ppt   = '0;
                        n_pfd   = 1'b0;
                        n_plast = 1'b1;
                    end else begin
                        n_ppt   = i_in.start_point;
                        n_pfd   = 1'b1;
                        n_plast = (act_n == CNT_W'(1));
                    end
                end
            end
            ST_EMIT: begin
                if (!r_ovalid || o_out.ready) begin
                    load_out = 1'b1;
                    if (r_plast) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_vis[r_cur] = 1'b1;
                        n_pos        = r_pos + CNT_W'(1);
                        n_col        = '0;
                        ctl.start    = 1'b1;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                // Sweep the current row, one column a cycle
                if (r_col < r_n) begin
                    ctl.issue = 1'b1;
                    ctl.last  = (r_col == r_n - CNT_W'(1));
                    n_col     = r_col + CNT_W'(1);
                end
                if (res.done) begin
                    n_ptp   = r_pos[PT_W-1:0];
                    n_state = ST_EMIT;
                    if (res.hit) begin
                        n_ppt   = res.pick;
                        n_pfd   = 1'b1;
                        n_plast = (r_pos + CNT_W'(1) == r_n);
                        n_cur   = res.pick;
                    end else begin
                        n_ppt   = '0;
                        n_pfd   = 1'b0;
                        n_plast = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_ovalid <= 1'b0;
            r_vis    <= '0;
            r_cur    <= '0;
            r_pos    <= '0;
            r_n      <= '0;
            r_col    <= '0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
            r_vis    <= n_vis;
            r_cur    <= n_cur;
            r_pos    <= n_pos;
            r_n      <= n_n;
            r_col    <= n_col;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ptp   <= n_ptp;
        r_ppt   <= n_ppt;
        r_pfd   <= n_pfd;
        r_plast <= n_plast;
        if (load_out) begin
            r_otp   <= r_ptp;
            r_opt   <= r_ppt;
            r_ofd   <= r_pfd;
            r_olast <= r_plast;
        end
    end

    assign o_out.valid         = r_ovalid;
    assign o_out.tour_position = r_otp;
    assign o_out.point_index   = r_opt;
    assign o_out.found         = r_ofd;
    assign o_out.last          = r_olast;

    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.done |-> r_state == ST_SCAN)
        else $error("scan finished outside of a tour step");

    a_pick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.done && res.hit) |-> CNT_W'(res.pick) < r_n)
        else $error("picked point beyond the active point count");

    a_pick_unvisited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (res.done && res.hit) |-> !r_vis[res.pick])
        else $error("picked point already visited");

    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SCAN |-> r_pos < r_n)
        else $error("tour position ran past the point count");

endmodule
